// ===== hw/rtl/bsc_pkg.sv =====
// bsc_pkg: shared types, codes, constants and commutation tables of the
// six-step sensorless commutator. No dependencies.
package bsc_pkg;

	// event operation codes
	localparam logic [2:0] OP_CROSSING = 3'd0;
	localparam logic [2:0] OP_EXPIRY   = 3'd1;
	localparam logic [2:0] OP_ENABLE   = 3'd2;
	localparam logic [2:0] OP_SET_DUTY = 3'd3;
	localparam logic [2:0] OP_DISABLE  = 3'd4;

	// event status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_BOUNCE  = 2'd1;
	localparam logic [1:0] STAT_REFUSED = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_REVERSE  = 2'd0;
	localparam logic [1:0] CFG_DEBOUNCE = 2'd1;
	localparam logic [1:0] CFG_MAX_DUTY = 2'd2;
	localparam logic [1:0] CFG_MIN_DUTY = 2'd3;

	// configuration reset values
	localparam logic [15:0] DEBOUNCE_RESET = 16'd500;
	localparam logic [7:0]  MAX_DUTY_RESET = 8'd249;
	localparam logic [7:0]  MIN_DUTY_RESET = 8'd25;

	// phase codes
	localparam logic [1:0] PH_A      = 2'd0;
	localparam logic [1:0] PH_B      = 2'd1;
	localparam logic [1:0] PH_C      = 2'd2;
	localparam logic [1:0] PH_NONE   = 2'd3;
	localparam logic [1:0] LOW_ALL   = 2'd3;
	localparam logic [3:0] PAT_BRAKE = {PH_NONE, LOW_ALL};

	// delay compare values
	localparam logic [15:0] DELAY_ENABLE = 16'd50000;
	localparam logic [15:0] DELAY_EXPIRY = 16'd65535;
	localparam logic [2:0]  LAST_STEP    = 3'd5;
	localparam logic [2:0]  NUM_STEPS    = 3'd6;

	typedef struct packed {
		logic [2:0]  operation;
		logic [15:0] timer_count;
		logic [7:0]  requested_duty;
	} event_t;

	typedef struct packed {
		logic [1:0]  high_side;
		logic [1:0]  low_side;
		logic [1:0]  sense_phase;
		logic        sense_falling;
		logic [15:0] delay_count;
		logic [7:0]  duty_now;
		logic        running;
		logic [1:0]  event_status;
		logic [2:0]  step_index;
	} result_t;

	typedef struct packed {
		logic        reverse_direction;
		logic [15:0] debounce_ticks;
		logic [7:0]  max_duty;
		logic [7:0]  min_duty;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  step_pos;
		logic [15:0] comm_count;
		logic [15:0] delay_value;
		logic [7:0]  duty_level;
		logic        enabled;
		logic [3:0]  drive_pattern;
	} state_t;

	localparam state_t STATE_RESET = '{
		step_pos: 3'd0, comm_count: 16'd0, delay_value: 16'd0,
		duty_level: 8'd0, enabled: 1'b0, drive_pattern: PAT_BRAKE};

	// bridge pattern per step: high phase in [3:2], low phase in [1:0]
	function automatic logic [3:0] drive_lookup(input logic rev, input logic [2:0] step);
		logic [3:0] pat;
		case ({rev, step})
			{1'b0, 3'd0}: pat = {PH_A, PH_B};
			{1'b0, 3'd1}: pat = {PH_A, PH_C};
			{1'b0, 3'd2}: pat = {PH_B, PH_C};
			{1'b0, 3'd3}: pat = {PH_B, PH_A};
			{1'b0, 3'd4}: pat = {PH_C, PH_A};
			{1'b0, 3'd5}: pat = {PH_C, PH_B};
			{1'b1, 3'd0}: pat = {PH_A, PH_B};
			{1'b1, 3'd1}: pat = {PH_C, PH_B};
			{1'b1, 3'd2}: pat = {PH_C, PH_A};
			{1'b1, 3'd3}: pat = {PH_B, PH_A};
			{1'b1, 3'd4}: pat = {PH_B, PH_C};
			{1'b1, 3'd5}: pat = {PH_A, PH_C};
			default:      pat = PAT_BRAKE;
		endcase
		return pat;
	endfunction

	// comparator setup per step: phase in [2:1], falling edge in [0]
	function automatic logic [2:0] sense_lookup(input logic rev, input logic [2:0] step);
		logic [2:0] sns;
		case ({rev, step})
			{1'b0, 3'd0}: sns = {PH_C, 1'b1};
			{1'b0, 3'd1}: sns = {PH_B, 1'b0};
			{1'b0, 3'd2}: sns = {PH_A, 1'b1};
			{1'b0, 3'd3}: sns = {PH_C, 1'b0};
			{1'b0, 3'd4}: sns = {PH_B, 1'b1};
			{1'b0, 3'd5}: sns = {PH_A, 1'b0};
			{1'b1, 3'd0}: sns = {PH_C, 1'b0};
			{1'b1, 3'd1}: sns = {PH_A, 1'b1};
			{1'b1, 3'd2}: sns = {PH_B, 1'b0};
			{1'b1, 3'd3}: sns = {PH_C, 1'b1};
			{1'b1, 3'd4}: sns = {PH_A, 1'b0};
			{1'b1, 3'd5}: sns = {PH_B, 1'b1};
			default:      sns = 3'd0;
		endcase
		return sns;
	endfunction

endpackage

// ===== hw/rtl/bsc_if.sv =====
// bsc_event_if / bsc_result_if: valid/ready channels carrying one item each.
// Depends on bsc_pkg for the payload types.
interface bsc_event_if import bsc_pkg::*;;
	logic   valid;
	logic   ready;
	event_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface bsc_result_if import bsc_pkg::*;;
	logic    valid;
	logic    ready;
	result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/bsc_cfg_regs.sv =====
// bsc_cfg_regs: configuration register file written through a plain write port.
// Depends on bsc_pkg.
module bsc_cfg_regs import bsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	// register writes, one index per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reverse_direction <= 1'b0;
			cfg_q.debounce_ticks    <= DEBOUNCE_RESET;
			cfg_q.max_duty          <= MAX_DUTY_RESET;
			cfg_q.min_duty          <= MIN_DUTY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_REVERSE:  cfg_q.reverse_direction <= cfg_data[0];
				CFG_DEBOUNCE: cfg_q.debounce_ticks    <= cfg_data;
				CFG_MAX_DUTY: cfg_q.max_duty          <= cfg_data[7:0];
				CFG_MIN_DUTY: cfg_q.min_duty          <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/bsc_event_logic.sv =====
// bsc_event_logic: next state and result for one event, pure combinational.
// Depends on bsc_pkg for types, codes and commutation tables.
module bsc_event_logic import bsc_pkg::*; (
	input  state_t  st,
	input  cfg_t    cfg,
	input  event_t  ev,
	output state_t  st_nxt,
	output result_t res
);

	logic [2:0]  step_cur;
	logic [2:0]  step_inc;
	logic [2:0]  step_out;
	logic [15:0] cnt_half;
	logic [15:0] wrap_delay;
	logic [15:0] cross_delay;
	logic [16:0] late_limit;
	logic [16:0] wrap_limit;
	logic        cross_late;
	logic        bounce;
	logic [7:0]  duty_clamped;
	logic        duty_low;
	logic [2:0]  sense;
	logic [1:0]  status;

	// current step, guarded against codes past the last step
	assign step_cur = (st.step_pos < NUM_STEPS) ? st.step_pos : 3'd0;
	assign step_inc = (step_cur == LAST_STEP) ? 3'd0 : step_cur + 3'd1;

	// crossing check: normal capture or rollover, sums kept in 17 bits
	assign cnt_half    = {1'b0, ev.timer_count[15:1]};
	assign wrap_delay  = {1'b1, ev.timer_count[15:1]};
	assign cross_late  = ev.timer_count > st.comm_count;
	assign late_limit  = {1'b0, st.comm_count} + {1'b0, cfg.debounce_ticks};
	assign wrap_limit  = {2'b00, st.comm_count[15:1]} + {2'b00, cfg.debounce_ticks[15:1]};
	assign cross_delay = cross_late ? cnt_half : wrap_delay;
	assign bounce      = cross_late ? ({1'b0, ev.timer_count} < late_limit)
	                                : ({1'b0, wrap_delay} < wrap_limit);

	// duty clamp and minimum check
	assign duty_clamped = (ev.requested_duty > cfg.max_duty) ? cfg.max_duty
	                                                         : ev.requested_duty;
	assign duty_low     = ev.requested_duty < cfg.min_duty;

	// event decode and state update
	always_comb begin
		st_nxt = st;
		status = STAT_OK;
		case (ev.operation)
			OP_CROSSING: begin
				if (!st.enabled) begin
					status = STAT_REFUSED;
				end else if (bounce) begin
					status = STAT_BOUNCE;
				end else begin
					st_nxt.delay_value = cross_delay;
					st_nxt.comm_count  = 16'd0;
					st_nxt.step_pos    = step_inc;
				end
			end
			OP_EXPIRY: begin
				if (!st.enabled) begin
					status = STAT_REFUSED;
				end else begin
					st_nxt.comm_count    = ev.timer_count;
					st_nxt.drive_pattern = drive_lookup(cfg.reverse_direction, step_cur);
					st_nxt.delay_value   = DELAY_EXPIRY;
				end
			end
			OP_ENABLE: begin
				if (duty_low) begin
					st_nxt.drive_pattern = PAT_BRAKE;
					st_nxt.duty_level    = 8'd0;
					st_nxt.enabled       = 1'b0;
					status               = STAT_REFUSED;
				end else if (st.enabled) begin
					status = STAT_REFUSED;
				end else begin
					st_nxt.delay_value = DELAY_ENABLE;
					st_nxt.enabled     = 1'b1;
					st_nxt.duty_level  = duty_clamped;
				end
			end
			OP_SET_DUTY: begin
				if (!st.enabled) begin
					status = STAT_REFUSED;
				end else if (duty_low) begin
					st_nxt.drive_pattern = PAT_BRAKE;
					st_nxt.duty_level    = 8'd0;
					st_nxt.enabled       = 1'b0;
				end else begin
					st_nxt.duty_level = duty_clamped;
				end
			end
			OP_DISABLE: begin
				st_nxt.drive_pattern = PAT_BRAKE;
				st_nxt.duty_level    = 8'd0;
				st_nxt.enabled       = 1'b0;
			end
			default: begin
				status = STAT_REFUSED;
			end
		endcase
	end

	// result from the updated state, comparator off while stopped
	assign step_out = (st_nxt.step_pos < NUM_STEPS) ? st_nxt.step_pos : 3'd0;
	assign sense    = st_nxt.enabled ? sense_lookup(cfg.reverse_direction, step_out) : 3'd0;

	assign res.high_side     = st_nxt.drive_pattern[3:2];
	assign res.low_side      = st_nxt.drive_pattern[1:0];
	assign res.sense_phase   = sense[2:1];
	assign res.sense_falling = sense[0];
	assign res.delay_count   = st_nxt.delay_value;
	assign res.duty_now      = st_nxt.duty_level;
	assign res.running       = st_nxt.enabled;
	assign res.event_status  = status;
	assign res.step_index    = step_out;

endmodule

// ===== hw/rtl/bldc_sensorless_commutator_core.sv =====
// bldc_sensorless_commutator_core: six-step sensorless commutation controller.
// Path: an accepted item enters the input register, then its result the result register.
// Throughput: one item per cycle unless the sink stalls; taking frees the result register.
// Reset (arst_n low, asynchronous): drive stopped, brake pattern, step 0, config defaults.
// Depends on bsc_pkg, bsc_if, bsc_cfg_regs and bsc_event_logic.
module bldc_sensorless_commutator_core import bsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	bsc_event_if.sink   evt,
	bsc_result_if.source res,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t    cfg;
	event_t  evt_s1;
	logic    evt_vld_s1;
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	result_t res_q;
	logic    res_vld_q;
	logic    advance;

	bsc_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bsc_event_logic u_event_logic (
		.st     (state_q),
		.cfg    (cfg),
		.ev     (evt_s1),
		.st_nxt (state_nxt),
		.res    (res_nxt)
	);

	// stage moves when the result register is empty or being taken
	assign advance   = !res_vld_q || res.ready;
	assign evt.ready = !evt_vld_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_vld_s1 <= 1'b0;
		end else if (evt.ready) begin
			evt_vld_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			evt_s1 <= evt.data;
		end
	end

	// controller state, updated once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance && evt_vld_s1) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (advance) begin
			res_vld_q <= evt_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && evt_vld_s1) begin
			res_q <= res_nxt;
		end
	end

	assign res.valid = res_vld_q;
	assign res.data  = res_q;

endmodule

// ===== hw/rtl/bsc_checker.sv =====
// bsc_checker: port-level assertions on the result channel of the commutator.
// Depends on bsc_pkg; bound to bldc_sensorless_commutator_core below.
module bsc_checker import bsc_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    res_valid,
	input logic    res_ready,
	input result_t res_data
);

	// a stalled item stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result item dropped while stalled");

	// a stalled item keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_data))
		else $error("result payload changed while stalled");

	// step position stays inside the six-step cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_data.step_index <= LAST_STEP)
		else $error("step index out of range");

	// a stopped drive brakes, has no duty and no comparator selection
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.running |->
			res_data.high_side == PH_NONE && res_data.low_side == LOW_ALL &&
			res_data.duty_now == 8'd0 && res_data.sense_phase == PH_A &&
			!res_data.sense_falling)
		else $error("stopped drive not braked");

	// status is one of the defined codes
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_data.event_status == STAT_OK ||
			res_data.event_status == STAT_BOUNCE ||
			res_data.event_status == STAT_REFUSED)
		else $error("undefined event status");

endmodule

bind bldc_sensorless_commutator_core bsc_checker u_bsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);
